### design/hta_pkg.sv
// Shared types and constants of the Hough track accumulator.
// Used by hta_span and by the top level hough_track_accumulator; no dependencies.
package hta_pkg;

  // Default array geometry and counter width.
  localparam int DEF_COLUMNS    = 64;
  localparam int DEF_ROWS       = 64;
  localparam int DEF_COUNT_BITS = 8;

  // Port widths fixed by the field layout.
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int VOTED_W     = 13;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_QPT_START  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QPT_STEP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHI_BEGIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHI_SCALE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD  = 3'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_VOTE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_VCOL,
    ST_VWAIT,
    ST_VROWS,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

### design/hta_span.sv
// Row span of one accumulator column: maps both q/pt cell edges of a hit to phi rows.
// Three-stage pipeline with two lanes; depends on hta_pkg.
module hta_span import hta_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int EW   = 34,
  localparam int RW  = $clog2(ROWS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [EW-1:0] e_lo,
  input  logic signed [EW-1:0] e_hi,
  input  logic [15:0]          radius,
  input  logic signed [23:0]   hit_phi,
  input  logic signed [23:0]   phi_begin,
  input  logic [15:0]          phi_scale,
  output logic                 done,
  output logic                 hit,
  output logic [RW-1:0]        row_lo,
  output logic [RW-1:0]        row_hi
);

  localparam int PW = EW + 17;
  localparam int DW = EW + 2;
  localparam int MW = DW + 17;
  localparam int VW = MW - 24;
  localparam logic signed [VW-1:0] ROW_MAX = VW'(ROWS - 1);
  localparam logic signed [MW-1:0] ROUND   = MW'(24'h800000);

  // Lane 0 is the bottom edge (upper q/pt edge), lane 1 the top edge.
  logic signed [EW-1:0] edge_w [2];
  logic signed [PW-1:0] prod_r [2];
  logic signed [DW-1:0] diff   [2];
  logic signed [MW-1:0] scl_r  [2];
  logic signed [MW-1:0] rsum   [2];
  logic signed [VW-1:0] rv     [2];
  logic signed [VW-1:0] bot_c, top_c;
  logic                 v1_r, v2_r, v3_r;
  logic                 hit_r;
  logic [RW-1:0]        lo_r, hi_r;

  assign edge_w[0] = e_hi;
  assign edge_w[1] = e_lo;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      diff[i] = DW'(hit_phi) - DW'($signed(prod_r[i][PW-1:17])) - DW'(phi_begin);
      rsum[i] = scl_r[i] + ROUND;
      rv[i]   = $signed(rsum[i][MW-1:24]);
    end
    bot_c = (rv[0] < 0) ? '0 : rv[0];
    top_c = (rv[1] > ROW_MAX) ? ROW_MAX : rv[1];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      prod_r[i] <= $signed({1'b0, radius}) * edge_w[i];
      scl_r[i]  <= diff[i] * $signed({1'b0, phi_scale});
    end
    hit_r <= !(rv[1] < 0) && !(rv[0] > ROW_MAX) && (bot_c <= top_c);
    lo_r  <= bot_c[RW-1:0];
    hi_r  <= top_c[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done   = v3_r;
  assign hit    = hit_r;
  assign row_lo = lo_r;
  assign row_hi = hi_r;

endmodule

### design/hough_track_accumulator.sv
// Hough track accumulator top level: vote store, command sequencer, config and output register.
// Depends on hta_pkg and hta_span.
//
//  Channel  Direction  Payload                                   Handshake
//  in_      request    tuser: command; tdata: radius, hit_phi,   in_tvalid / in_tready
//                      column, row
//  out_     result     tdata: cell_count, above_threshold,       out_tvalid / out_tready
//                      cells_voted
//  cfg_     write      cfg_index, cfg_data                       cfg_valid / cfg_ready
//
// A vote request walks the columns in turn: the span pipeline maps each column to a row
// span, each covered cell then gets a read-modify-write through the vote store, and the
// result is handed off last. A clear request sweeps the store, one store entry a cycle.
// After reset the store is swept to zero, in_tready staying low;
// configuration writes are taken throughout. The output register lets the next request be
// accepted while a result waits; a stalled result holds the sequencer in its final state.
module hough_track_accumulator import hta_pkg::*; #(
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata from bit 0 up: radius[15:0], hit_phi[23:0], column[5:0], row[5:0], zero pad.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: command[1:0].
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata from bit 0 up: cell_count[7:0], above_threshold, cells_voted[12:0], zero pad.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  // Doubled column centre plus or minus one step fits comfortably in EW signed bits.
  localparam int EW    = CW + 28;

  // Request fields.
  cmd_t               in_cmd;
  logic [15:0]        in_radius;
  logic signed [23:0] in_phi;
  logic [5:0]         in_col;
  logic [5:0]         in_row;
  logic               in_acc;
  logic               in_range;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_radius = in_tdata[15:0];
  assign in_phi    = $signed(in_tdata[39:16]);
  assign in_col    = in_tdata[45:40];
  assign in_row    = in_tdata[51:46];
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = (32'(in_col) < COLUMNS) && (32'(in_row) < ROWS);

  // Configuration registers; the port never stalls.
  logic signed [23:0] qpt_start_r;
  logic [22:0]        qpt_step_r;
  logic signed [23:0] phi_begin_r;
  logic [15:0]        phi_scale_r;
  logic [7:0]         thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpt_start_r <= '0;
      qpt_step_r  <= '0;
      phi_begin_r <= '0;
      phi_scale_r <= '0;
      thr_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QPT_START: qpt_start_r <= $signed(cfg_data[23:0]);
        CFG_QPT_STEP:  qpt_step_r  <= cfg_data[22:0];
        CFG_PHI_BEGIN: phi_begin_r <= $signed(cfg_data[23:0]);
        CFG_PHI_SCALE: phi_scale_r <= cfg_data[15:0];
        CFG_THRESHOLD: thr_r       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers.
  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r;
  logic                 clr_last;
  logic [15:0]          radius_r;
  logic signed [23:0]   phi_r;
  logic [CW-1:0]        col_r;
  logic                 col_last;
  logic signed [EW-1:0] centre2_r;
  logic signed [EW-1:0] e_lo, e_hi;
  logic [AW-1:0]        addr_r;
  logic [RW-1:0]        k_r, top_r;
  logic                 row_last;
  logic                 rd_ok_r;
  logic [7:0]           res_count_r;
  logic                 res_above_r;
  logic [VOTED_W-1:0]   voted_r;

  // Span unit handshake.
  logic                 span_start;
  logic                 span_done;
  logic                 span_hit;
  logic [RW-1:0]        span_lo, span_hi;

  // Vote store ports.
  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;
  logic                  wb_pend_r;
  logic [AW-1:0]         wb_addr_r;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                  out_free;
  logic                  out_load;

  assign clr_last = (clr_r == AW'(CELLS - 1));
  assign col_last = (col_r == CW'(COLUMNS - 1));
  assign row_last = (k_r == top_r);
  assign out_free = !out_valid_r || out_tready;
  assign e_lo     = centre2_r - EW'(qpt_step_r);
  assign e_hi     = centre2_r + EW'(qpt_step_r);

  hta_span #(
    .ROWS (ROWS),
    .EW   (EW)
  ) u_span (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (span_start),
    .e_lo      (e_lo),
    .e_hi      (e_hi),
    .radius    (radius_r),
    .hit_phi   (phi_r),
    .phi_begin (phi_begin_r),
    .phi_scale (phi_scale_r),
    .done      (span_done),
    .hit       (span_hit),
    .row_lo    (span_lo),
    .row_hi    (span_hi)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_VOTE:  state_nxt = ST_VCOL;
            CMD_READ:  state_nxt = ST_READ;
            CMD_NOP:   state_nxt = ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: if (clr_last) state_nxt = ST_DONE;
      ST_VCOL:  state_nxt = ST_VWAIT;
      ST_VWAIT: begin
        if (span_done) begin
          if (span_hit) begin
            state_nxt = ST_VROWS;
          end else begin
            state_nxt = col_last ? ST_DONE : ST_VCOL;
          end
        end
      end
      ST_VROWS: if (row_last) state_nxt = col_last ? ST_DONE : ST_VCOL;
      ST_READ:  state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    span_start = (state_r == ST_VCOL);
    out_load   = (state_r == ST_DONE) && out_free;
    rd_en      = 1'b0;
    rd_addr    = addr_r;
    mem_we     = 1'b0;
    mem_wa     = wb_addr_r;
    mem_wd     = (rd_data_r == '1) ? rd_data_r : COUNT_BITS'(rd_data_r + 1'b1);
    unique case (state_r)
      ST_IDLE: begin
        rd_en   = in_acc && (in_cmd == CMD_READ);
        rd_addr = AW'(in_row) * AW'(ROWS > 0 ? COLUMNS : 1) + AW'(in_col);
      end
      ST_VROWS: rd_en = 1'b1;
      default: ;
    endcase
    // Sweeps write zeros; otherwise the pending increment goes back.
    if ((state_r == ST_INIT) || (state_r == ST_CLEAR)) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (wb_pend_r) begin
      mem_we = 1'b1;
    end
  end

  // Vote store: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      clr_r     <= '0;
      wb_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wb_pend_r <= (state_r == ST_VROWS);
      if ((state_r == ST_INIT) || (state_r == ST_CLEAR)) begin
        clr_r <= clr_last ? '0 : clr_r + 1'b1;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    wb_addr_r <= addr_r;
    if (in_acc) begin
      radius_r    <= in_radius;
      phi_r       <= in_phi;
      col_r       <= '0;
      centre2_r   <= EW'(qpt_start_r) <<< 1;
      rd_ok_r     <= in_range;
      res_count_r <= '0;
      res_above_r <= 1'b0;
      voted_r     <= '0;
    end
    unique case (state_r)
      ST_VWAIT: begin
        if (span_done) begin
          if (span_hit) begin
            addr_r <= AW'(span_lo) * AW'(COLUMNS) + AW'(col_r);
            k_r    <= span_lo;
            top_r  <= span_hi;
          end else begin
            col_r     <= col_r + 1'b1;
            centre2_r <= centre2_r + EW'({qpt_step_r, 1'b0});
          end
        end
      end
      ST_VROWS: begin
        addr_r  <= addr_r + AW'(COLUMNS);
        k_r     <= k_r + 1'b1;
        voted_r <= voted_r + 1'b1;
        if (row_last) begin
          col_r     <= col_r + 1'b1;
          centre2_r <= centre2_r + EW'({qpt_step_r, 1'b0});
        end
      end
      ST_READ: begin
        if (rd_ok_r) begin
          res_count_r <= (16'(rd_data_r) > 16'd255) ? 8'hFF : 8'(rd_data_r);
          res_above_r <= (16'(rd_data_r) > 16'(thr_r));
        end
      end
      default: ;
    endcase
  end

  // Result register parts the sequencer from the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {2'b00, voted_r, res_above_r, res_count_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/hta_checker.sv
// Scoreboard for the Hough track accumulator: watches the request, result and configuration
// channels, keeps its own vote store and register copy, and checks every result in order.
// Depends on hta_pkg for port widths, register indexes and command codes.
module hta_checker import hta_pkg::*; #(
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  typedef struct packed {
    logic [VOTED_W-1:0] voted;
    logic               flag;
    logic [7:0]         count;
  } outcome_t;

  // Vote store, indexed row * COLUMNS + column.
  longint   tally [COLUMNS*ROWS];
  longint   qpt_origin, qpt_width, phi_origin, rows_per_rad, threshold;
  outcome_t awaited_q [$];

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic longint phi_to_row_index(longint p);
    return ((p - phi_origin) * rows_per_rad + (longint'(1) << 23)) >>> 24;
  endfunction

  // Walks every column, maps the doubled cell edges to a row span, clips it to the grid
  // and bumps each covered counter. Returns the number of cells covered.
  function automatic int cast_votes(longint radius, longint phi);
    int     covered;
    int     c;
    longint mid2, top, bot, k;
    covered = 0;
    for (c = 0; c < COLUMNS; c++) begin
      mid2 = 2 * (qpt_origin + c * qpt_width);
      top  = phi_to_row_index(phi - ((radius * (mid2 - qpt_width)) >>> 17));
      bot  = phi_to_row_index(phi - ((radius * (mid2 + qpt_width)) >>> 17));
      if (top >= 0 && bot <= ROWS - 1) begin
        if (bot < 0) bot = 0;
        if (top > ROWS - 1) top = ROWS - 1;
        for (k = bot; k <= top; k++) begin
          if (tally[k * COLUMNS + c] < COUNT_MAX) tally[k * COLUMNS + c]++;
          covered++;
        end
      end
    end
    return covered;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    longint   votes_in_cell;
    int       col, row;
    if (!rst_n) begin
      foreach (tally[i]) tally[i] = 0;
      qpt_origin   = 0;
      qpt_width    = 0;
      phi_origin   = 0;
      rows_per_rad = 0;
      threshold    = 0;
      awaited_q.delete();
      fail_count = 0;
    end else begin
      // Results first: a request taken on this edge cannot have its result out yet.
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          flag_mismatch("unrequested result", out_tdata, 0);
        end else begin
          want = awaited_q.pop_front();
          if (out_tdata[7:0] !== want.count)
            flag_mismatch("cell_count", out_tdata[7:0], want.count);
          if (out_tdata[8] !== want.flag)
            flag_mismatch("above_threshold", out_tdata[8], want.flag);
          if (out_tdata[21:9] !== want.voted)
            flag_mismatch("cells_voted", out_tdata[21:9], want.voted);
          if (out_tdata[OUT_TDATA_W-1:22] !== '0)
            flag_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:22], 0);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QPT_START: qpt_origin   = longint'($signed(cfg_data));
          CFG_QPT_STEP:  qpt_width    = longint'(cfg_data[22:0]);
          CFG_PHI_BEGIN: phi_origin   = longint'($signed(cfg_data));
          CFG_PHI_SCALE: rows_per_rad = longint'(cfg_data[15:0]);
          CFG_THRESHOLD: threshold    = longint'(cfg_data[7:0]);
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        want = '0;
        case (cmd_t'(in_tuser))
          CMD_CLEAR: foreach (tally[i]) tally[i] = 0;
          CMD_VOTE:  want.voted = cast_votes(longint'(in_tdata[15:0]),
                                             longint'($signed(in_tdata[39:16])));
          CMD_READ: begin
            col = in_tdata[45:40];
            row = in_tdata[51:46];
            if (col < COLUMNS && row < ROWS) begin
              votes_in_cell = tally[row * COLUMNS + col];
              want.count    = votes_in_cell > 255 ? 8'd255 : votes_in_cell[7:0];
              want.flag     = votes_in_cell > threshold;
            end
          end
          default: ;
        endcase
        awaited_q.push_back(want);
      end
    end
    pending = awaited_q.size();
  end

endmodule

### tb/testbench.sv
// Top of the Hough track accumulator bench: clock, reset, request and configuration
// stimulus, result back-pressure and the final verdict.
// Depends on hta_pkg, the hough_track_accumulator RTL and the hta_checker scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hta_pkg::*;

  // Request payload in tdata order; the first member sits in the top bits.
  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  column;
    logic [23:0] phi;
    logic [15:0] radius;
  } request_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;

  // Random gaps on both channels are allowed while this is set.
  bit     idle_on = 1'b1;
  int     results_seen = 0;

  // Geometry of the current phase, used to aim hits at the grid.
  longint start_now, step_now, origin_now, scale_now, span_now;
  longint track_qpt [3];
  longint track_phi [3];
  longint track_col [3];
  longint track_row [3];

  hough_track_accumulator DUT (.*);
  hta_checker monitor (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net well past the slowest legal run (every vote covering the whole grid).
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) results_seen <= results_seen + 1;
  end

  // Result side. Once, after a few hundred results, the receiver holds off for a long
  // stretch so the output register and the sequencer fill up and in_tready drops while
  // requests keep being offered. Otherwise it stalls in short random bursts if idle_on.
  initial begin
    int hold_left;
    int burst_left;
    bit held;
    hold_left  = 0;
    burst_left = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300) begin
        held      = 1'b1;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic longint pick(int unsigned lo, int unsigned hi);
    return longint'($urandom_range(lo, hi));
  endfunction

  function automatic request_t random_request();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return noise[$bits(request_t)-1:0];
  endfunction

  // Offers one request, waits for it to be taken and sometimes leaves a gap after it.
  // The task returns on a falling edge with tvalid still high unless a gap was taken.
  task automatic issue(cmd_t cmd, request_t req);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - $bits(request_t)){1'b0}}, req};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic issue_vote(longint radius, longint phi);
    request_t req;
    req        = random_request();
    req.radius = radius[15:0];
    req.phi    = phi[23:0];
    issue(CMD_VOTE, req);
  endtask

  task automatic issue_read(longint col, longint row);
    request_t req;
    req        = random_request();
    req.column = col[5:0];
    req.row    = row[5:0];
    issue(CMD_READ, req);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers may only change while the block is idle, so drain every outstanding
  // result first. Each request yields exactly one result, so an empty scoreboard
  // means the sequencer is back in its idle state.
  task automatic set_config(longint qs, longint step, longint pb, longint scale, longint th);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(CFG_QPT_START, qs[23:0]);
    write_reg(CFG_QPT_STEP, step[23:0]);
    write_reg(CFG_PHI_BEGIN, pb[23:0]);
    write_reg(CFG_PHI_SCALE, scale[23:0]);
    write_reg(CFG_THRESHOLD, th[23:0]);
    cfg_valid <= 1'b0;
  endtask

  // A grid where tracks cross diagonally: a span is a few rows tall and the central
  // columns sit near zero q/pt. Most hits lie on one of three tracks, so some cells
  // collect real peaks; the rest land anywhere in the grid, plus a little pure noise.
  task automatic typical_phase(int items, bit quiet);
    request_t req;
    longint   r, p, offset;
    int       roll, t;
    idle_on    = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    step_now   = pick(32, 1024);
    scale_now  = pick(16384, 65535);
    origin_now = pick(0, 2097152) - 1048576;
    start_now  = -32 * step_now + pick(0, 2 * step_now) - step_now;
    span_now   = (longint'(64) << 24) / scale_now;
    set_config(start_now, step_now, origin_now, scale_now, pick(0, 3));
    for (t = 0; t < 3; t++) begin
      track_col[t] = pick(0, 63);
      track_qpt[t] = start_now + track_col[t] * step_now;
      offset       = pick(0, span_now);
      track_phi[t] = origin_now + offset;
      track_row[t] = (offset * scale_now) >>> 24;
    end
    if ($urandom_range(0, 1) == 0) issue(CMD_CLEAR, random_request());
    repeat (items) begin
      roll = $urandom_range(0, 99);
      t    = $urandom_range(0, 2);
      r    = pick(0, 65535);
      if (roll < 1) begin
        issue(CMD_CLEAR, random_request());
      end else if (roll < 4) begin
        issue(CMD_NOP, random_request());
      end else if (roll < 24) begin
        issue_read(track_col[t] + pick(0, 2) - 1, track_row[t] + pick(0, 2) - 1);
      end else if (roll < 44) begin
        issue(CMD_READ, random_request());
      end else if (roll < 80) begin
        // The hit phi that puts this track's q/pt column on its phi row.
        p = track_phi[t] + ((r * track_qpt[t]) >>> 16);
        issue_vote(r, p);
      end else if (roll < 95) begin
        issue_vote(r, origin_now + pick(0, span_now));
      end else begin
        req = random_request();
        issue(CMD_VOTE, req);
      end
    end
  endtask

  // With a zero scale every span collapses onto row zero, so each vote bumps the whole
  // bottom row and a few hundred votes drive it into saturation.
  task automatic saturation_phase(int items);
    request_t req;
    idle_on = ($urandom_range(0, 3) != 0);
    set_config(pick(0, 16777215), pick(0, 16777215), pick(0, 16777215), 0, 254);
    issue(CMD_CLEAR, random_request());
    repeat (items) begin
      req = random_request();
      if ($urandom_range(0, 9) < 7) begin
        issue(CMD_VOTE, req);
      end else begin
        if ($urandom_range(0, 3) != 0) req.row = '0;
        issue(CMD_READ, req);
      end
    end
  endtask

  // Register extremes make spans cover whole columns; kept short since such votes are slow.
  task automatic extreme_phase(longint qs, longint step, longint pb, longint scale, longint th);
    idle_on = ($urandom_range(0, 1) != 0);
    set_config(qs, step, pb, scale, th);
    repeat (20) begin
      if ($urandom_range(0, 9) < 6) issue(CMD_VOTE, random_request());
      else issue(CMD_READ, random_request());
    end
  endtask

  // Fully random registers and requests; clears are left to the other phases.
  task automatic noise_phase(int items);
    int roll;
    idle_on = 1'b1;
    set_config(pick(0, 16777215), pick(0, 16777215), pick(0, 16777215),
               pick(0, 16777215), pick(0, 16777215));
    repeat (items) begin
      roll = $urandom_range(0, 2);
      if (roll == 0) issue(CMD_VOTE, random_request());
      else if (roll == 1) issue(CMD_READ, random_request());
      else issue(CMD_NOP, random_request());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_NOP;
    cfg_valid = 1'b0;
    cfg_index = CFG_QPT_START;
    cfg_data  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: zero scale and zero step, so every vote covers row zero
    // of all columns, whatever the radius and phi extremes. The first request also
    // waits out the clearing sweep that follows reset.
    issue_read(0, 0);
    issue_read(63, 63);
    issue_vote(0, 0);
    issue_vote(65535, 24'h7FFFFF);
    issue_vote(32768, 24'h800000);
    issue(CMD_NOP, request_t'('1));
    issue_read(0, 0);
    issue_read(63, 63);
    issue_read(17, 0);
    issue(CMD_CLEAR, random_request());
    issue_read(0, 0);

    // A hand-picked grid: 64 rows span phi -8192 to +8192, central column near zero.
    set_config(-16384, 512, -8192, 65535, 1);
    issue_vote(0, 0);
    issue_vote(40000, 0);
    // Spans straddling the bottom and top edges get clipped to the grid.
    issue_vote(65535, -8192);
    issue_vote(65535, 8191);
    // Spans wholly below and wholly above the grid vote nothing.
    issue_vote(0, -1048576);
    issue_vote(0, 1048576);
    issue_read(32, 32);
    issue_read(0, 32);
    issue_read(63, 0);
    issue(CMD_NOP, request_t'('0));

    typical_phase(135, 1'b0);
    typical_phase(135, 1'b0);
    extreme_phase(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 65535, 255);
    typical_phase(135, 1'b0);
    saturation_phase(400);
    typical_phase(135, 1'b0);
    noise_phase(60);
    extreme_phase(24'h7FFFFF, 0, 24'h800000, 1, 0);
    typical_phase(135, 1'b0);
    typical_phase(135, 1'b0);
    typical_phase(135, 1'b0);
    // Closing stretch runs with no gaps on either side.
    typical_phase(135, 1'b1);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // Nothing should arrive after the last result, so keep watching before the verdict.
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
